// ----- design/assert_macros.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: implication check failed");

// Next-cycle implication.
`define ASSERT_NXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMP(name, clk, rst, pre, post)
`define ASSERT_NXT(name, clk, rst, pre, post)

`endif

`endif

// ----- design/pbd_pkg.sv -----
// Types and constants for the packet batch deframer.
`timescale 1ns / 1ps
`default_nettype none

package pbd_pkg;

  localparam int BATCH_HDR_BYTES = 24;
  localparam int LEN_BYTES       = 2;
  localparam int WORD_BYTES      = 16;
  localparam int PREFIX_BYTES    = LEN_BYTES + WORD_BYTES;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_OK     = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [1:0] ERR_BATCH_SHORT = 2'd0;
  localparam logic [1:0] ERR_PREFIX_CUT  = 2'd1;
  localparam logic [1:0] ERR_DATA_CUT    = 2'd2;

  localparam logic REG_EMIT_ENABLE = 1'b0;

  typedef enum logic [2:0] {
    PH_BATCH  = 3'd0,
    PH_PREFIX = 3'd1,
    PH_DATA   = 3'd2,
    PH_TAIL   = 3'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       msg_last;
  } msg_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] packet_number;
    logic [31:0] ts_seconds;
    logic [31:0] ts_microseconds;
    logic [31:0] capture_length;
    logic [31:0] wire_length;
    logic [15:0] data_length;
    logic [7:0]  data_byte;
    logic        last_data;
    logic [1:0]  error_code;
    logic [15:0] batch_packet_count;
  } res_beat_t;

  // Up to two results from one message beat: packet result, then end result.
  typedef struct packed {
    logic      a_valid;
    logic      b_valid;
    res_beat_t a;
    res_beat_t b;
  } res_push_t;

endpackage

`default_nettype wire

// ----- design/pbd_queue.sv -----
// Small result queue: takes up to two results per cycle, hands out one per beat.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pbd_queue (
  input  logic              clk,
  input  logic              rst,
  input  pbd_pkg::res_push_t push,
  output logic              room,
  output logic              res_valid,
  input  logic              res_ready,
  output pbd_pkg::res_beat_t res
);
  import pbd_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_beat_t        entries [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] wr0;
  logic [PTR_W-1:0] wr1;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       push_n;
  logic             pop;
  res_beat_t        first;

  assign push_n    = {1'b0, push.a_valid} + {1'b0, push.b_valid};
  assign first     = push.a_valid ? push.a : push.b;
  assign wr0       = head + count[PTR_W-1:0];
  assign wr1       = wr0 + PTR_W'(1);
  assign room      = (count <= CNT_W'(DEPTH - 2));
  assign res_valid = (count != '0);
  assign res       = entries[head];
  assign pop       = res_valid & res_ready;
  assign count_next = count + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head + PTR_W'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr0] <= first;
    end
    if (push_n == 2'd2) begin
      entries[wr1] <= push.b;
    end
  end

  `ASSERT_IMP(a_push_needs_room, clk, rst, push_n != 2'd0, room)
  `ASSERT_NXT(a_pop_drains, clk, rst, pop && (push_n == 2'd0), count == $past(count) - CNT_W'(1))
  `ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

// ----- design/packet_batch_deframer.sv -----
// Top level: batch message parser, result queue and register port.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+----------------------------
//  msg      | msg_valid / msg_ready           | msg (msg_byte, msg_last)
//  res      | res_valid / res_ready           | res (packet header, data,
//           |                                 |      ok or error results)
//  config   | psel/penable/pwrite, pready = 1 | paddr, pwdata, prdata
//
// One message byte is taken per cycle; the parser state updates in that cycle
// and its results land in a four-entry queue that drives res.
// A byte gives at most two results; msg_ready drops while the queue holds
// more than two, so sustained rate is one byte per cycle while res drains.
// Synchronous reset returns the parser to the batch header and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module packet_batch_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  output logic               msg_ready,
  input  pbd_pkg::msg_beat_t msg,
  output logic               res_valid,
  input  logic               res_ready,
  output pbd_pkg::res_beat_t res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pbd_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [4:0]  byte_position;
  logic [4:0]  byte_position_next;
  logic [15:0] packets_total;
  logic [15:0] packets_total_next;
  logic [15:0] packets_done;
  logic [15:0] packets_done_next;
  logic [15:0] data_remaining;
  logic [15:0] data_remaining_next;
  logic [31:0] header_words [4];
  logic [31:0] header_words_next [4];
  logic        emit_enable;

  logic        accept;
  logic        room;
  logic        finish;
  logic [4:0]  word_offset;
  logic [1:0]  word_sel;
  res_push_t   push;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EMIT_ENABLE) ? {31'd0, emit_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_enable <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == REG_EMIT_ENABLE)) begin
      emit_enable <= pwdata[0];
    end
  end

  assign msg_ready   = room;
  assign accept      = msg_valid & msg_ready;
  assign word_offset = byte_position - 5'(LEN_BYTES);
  assign word_sel    = word_offset[3:2];

  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    packets_total_next  = packets_total;
    packets_done_next   = packets_done;
    data_remaining_next = data_remaining;
    header_words_next   = header_words;
    finish              = 1'b0;
    push                = '0;

    if (accept) begin
      unique case (phase)
        PH_BATCH: begin
          if (byte_position == 5'd2) begin
            packets_total_next = {msg.msg_byte, 8'd0};
          end else if (byte_position == 5'd3) begin
            packets_total_next = {packets_total[15:8], msg.msg_byte};
          end
          byte_position_next = byte_position + 5'd1;
          if (byte_position == 5'(BATCH_HDR_BYTES - 1)) begin
            byte_position_next = '0;
            phase_next = (packets_total_next == 16'd0) ? PH_TAIL : PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          if (byte_position == 5'd0) begin
            data_remaining_next = {msg.msg_byte, 8'd0};
          end else if (byte_position == 5'd1) begin
            data_remaining_next = {data_remaining[15:8], msg.msg_byte};
          end else begin
            header_words_next[word_sel] = {header_words[word_sel][23:0], msg.msg_byte};
          end
          byte_position_next = byte_position + 5'd1;
          if (byte_position == 5'(PREFIX_BYTES - 1)) begin
            push.a_valid                = emit_enable;
            push.a.kind                 = KIND_HEADER;
            push.a.packet_number        = packets_done + 16'd1;
            push.a.ts_seconds           = header_words_next[0];
            push.a.ts_microseconds      = header_words_next[1];
            push.a.capture_length       = header_words_next[2];
            push.a.wire_length          = header_words_next[3];
            push.a.data_length          = data_remaining;
            byte_position_next          = '0;
            if (data_remaining == 16'd0) begin
              finish = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          push.a_valid         = emit_enable;
          push.a.kind          = KIND_DATA;
          push.a.packet_number = packets_done + 16'd1;
          push.a.data_byte     = msg.msg_byte;
          push.a.last_data     = (data_remaining == 16'd1);
          data_remaining_next  = data_remaining - 16'd1;
          if (data_remaining_next == 16'd0) begin
            finish = 1'b1;
          end
        end
        PH_TAIL: begin
          // trailing bytes after the last counted packet are dropped
        end
        default: begin
          phase_next = PH_BATCH;
        end
      endcase

      if (finish) begin
        packets_done_next  = packets_done + 16'd1;
        byte_position_next = '0;
        phase_next = (packets_done_next >= packets_total_next) ? PH_TAIL : PH_PREFIX;
      end

      if (msg.msg_last) begin
        push.b_valid              = 1'b1;
        push.b.batch_packet_count = packets_total_next;
        push.b.packet_number      = packets_done_next + 16'd1;
        push.b.kind               = KIND_ERROR;
        unique case (phase_next)
          PH_BATCH: begin
            push.b.error_code         = ERR_BATCH_SHORT;
            push.b.packet_number      = 16'd0;
            push.b.batch_packet_count = 16'd0;
          end
          PH_PREFIX: push.b.error_code = ERR_PREFIX_CUT;
          PH_DATA:   push.b.error_code = ERR_DATA_CUT;
          default: begin
            push.b.kind          = KIND_OK;
            push.b.packet_number = 16'd0;
          end
        endcase
        // message ends: next byte opens a new batch header
        phase_next          = PH_BATCH;
        byte_position_next  = '0;
        packets_total_next  = '0;
        packets_done_next   = '0;
        data_remaining_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_BATCH;
      byte_position  <= '0;
      packets_total  <= '0;
      packets_done   <= '0;
      data_remaining <= '0;
    end else begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      packets_total  <= packets_total_next;
      packets_done   <= packets_done_next;
      data_remaining <= data_remaining_next;
    end
  end

  // header words are always fully shifted in before they are shown
  always_ff @(posedge clk) begin
    header_words <= header_words_next;
  end

  pbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  `ASSERT_NXT(a_last_restarts, clk, rst, accept && msg.msg_last, (phase == PH_BATCH) && (byte_position == 5'd0) && (packets_done == 16'd0))
  `ASSERT_IMP(a_data_nonzero, clk, rst, phase == PH_DATA, data_remaining != 16'd0)
  `ASSERT_IMP(a_batch_no_done, clk, rst, phase == PH_BATCH, packets_done == 16'd0)

endmodule

`default_nettype wire

// ----- bench/packet_batch_deframer_tb.sv -----
// Self-checking testbench for the packet batch deframer.
`timescale 1ns / 1ps

module packet_batch_deframer_tb;
  import pbd_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int WATCHDOG_CYCLES = 600000;
  localparam int PHASE_BYTES = 60;
  localparam int NO_CUT = -1;
  localparam int RANDOM_CUT = -2;
  localparam int RANDOM_LEN = -1;
  localparam logic [1:0] CODE_NONE = 2'd0;
  localparam logic [2:0] EMIT_ENABLE_ADDR = 3'(4 * REG_EMIT_ENABLE);

  typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

  // One message: batch count, packets actually built, data length per packet,
  // truncation point, ignored tail bytes, and optionally a typed end beat.
  typedef struct {
    int         count;
    int         npk;
    int         dlen;
    int         cut;
    int         tail;
    fill_t      fill;
    bit         typed;
    logic [1:0] ekind;
    logic [1:0] ecode;
    int         epkt;
    int         ecount;
  } msg_plan_t;

  typedef struct {
    bit        typed;
    res_beat_t r;
  } ending_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_ready;
  msg_beat_t   msg = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_beat_t   res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  packet_batch_deframer DUT (
    .clk(clk), .rst(rst),
    .msg_valid(msg_valid), .msg_ready(msg_ready), .msg(msg),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Deframer shadow state
  logic        emit_on = 1'b1;
  phase_t      ph = PH_BATCH;
  int          pos = 0;
  logic [15:0] pk_total = '0;
  logic [15:0] pk_done = '0;
  logic [15:0] remaining = '0;
  logic [31:0] hdr_words [4];

  res_beat_t   due_results [$];
  ending_t     typed_endings [$];
  logic [7:0]  msg_bytes [$];

  int errors = 0;
  int results_checked = 0;
  int kind_seen [4];
  int bytes_sent = 0;
  int msgs_sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;

  msg_plan_t directed_plan [14];

  function automatic void clear_parser();
    ph = PH_BATCH;
    pos = 0;
    pk_total = '0;
    pk_done = '0;
    remaining = '0;
    foreach (hdr_words[i]) hdr_words[i] = '0;
  endfunction

  function automatic void close_packet();
    pk_done = pk_done + 16'd1;
    pos = 0;
    ph = (pk_done >= pk_total) ? PH_TAIL : PH_PREFIX;
  endfunction

  // Works out the result beats caused by one message beat.
  function automatic void deframe_beat(input logic [7:0] b, input logic l);
    res_beat_t r;
    int w;
    ending_t te;
    case (ph)
      PH_BATCH: begin
        if (pos == 2) pk_total = {b, 8'h00};
        else if (pos == 3) pk_total[7:0] = b;
        pos++;
        if (pos >= BATCH_HDR_BYTES) begin
          pos = 0;
          ph = (pk_total == 16'd0) ? PH_TAIL : PH_PREFIX;
        end
      end
      PH_PREFIX: begin
        if (pos == 0) remaining = {b, 8'h00};
        else if (pos == 1) remaining[7:0] = b;
        else begin
          w = ((pos - LEN_BYTES) >> 2) & 3;
          hdr_words[w] = {hdr_words[w][23:0], b};
        end
        pos++;
        if (pos >= PREFIX_BYTES) begin
          if (emit_on) begin
            r = '0;
            r.kind = KIND_HEADER;
            r.packet_number = pk_done + 16'd1;
            r.ts_seconds = hdr_words[0];
            r.ts_microseconds = hdr_words[1];
            r.capture_length = hdr_words[2];
            r.wire_length = hdr_words[3];
            r.data_length = remaining;
            due_results.push_back(r);
          end
          pos = 0;
          if (remaining == 16'd0) close_packet();
          else ph = PH_DATA;
        end
      end
      PH_DATA: begin
        if (emit_on) begin
          r = '0;
          r.kind = KIND_DATA;
          r.packet_number = pk_done + 16'd1;
          r.data_byte = b;
          r.last_data = (remaining == 16'd1);
          due_results.push_back(r);
        end
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) close_packet();
      end
      default: ;
    endcase
    if (l) begin
      r = '0;
      case (ph)
        PH_BATCH: begin
          r.kind = KIND_ERROR;
          r.error_code = ERR_BATCH_SHORT;
        end
        PH_PREFIX: begin
          r.kind = KIND_ERROR;
          r.error_code = ERR_PREFIX_CUT;
          r.packet_number = pk_done + 16'd1;
          r.batch_packet_count = pk_total;
        end
        PH_DATA: begin
          r.kind = KIND_ERROR;
          r.error_code = ERR_DATA_CUT;
          r.packet_number = pk_done + 16'd1;
          r.batch_packet_count = pk_total;
        end
        default: begin
          r.kind = KIND_OK;
          r.batch_packet_count = pk_total;
        end
      endcase
      // directed messages with typed set carry their end beat written out by hand
      if (typed_endings.size() != 0) begin
        te = typed_endings.pop_front();
        if (te.typed) r = te.r;
      end
      due_results.push_back(r);
      clear_parser();
    end
  endfunction

  function automatic void cmp_field(input string f, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0h, actual %0h", $time, f, want, got);
    end
  endfunction

  function automatic void check_result(input res_beat_t got);
    res_beat_t want;
    if (due_results.size() == 0) begin
      errors++;
      $display("%0t ns: result beat with nothing expected, actual kind %0d pkt %0d",
               $time, got.kind, got.packet_number);
    end else begin
      want = due_results.pop_front();
      results_checked++;
      kind_seen[want.kind]++;
      cmp_field("kind", want.kind, got.kind);
      cmp_field("packet_number", want.packet_number, got.packet_number);
      cmp_field("ts_seconds", want.ts_seconds, got.ts_seconds);
      cmp_field("ts_microseconds", want.ts_microseconds, got.ts_microseconds);
      cmp_field("capture_length", want.capture_length, got.capture_length);
      cmp_field("wire_length", want.wire_length, got.wire_length);
      cmp_field("data_length", want.data_length, got.data_length);
      cmp_field("data_byte", want.data_byte, got.data_byte);
      cmp_field("last_data", want.last_data, got.last_data);
      cmp_field("error_code", want.error_code, got.error_code);
      cmp_field("batch_packet_count", want.batch_packet_count, got.batch_packet_count);
    end
  endfunction

  // Input beats are predicted before output beats are checked in the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (msg_valid && msg_ready) deframe_beat(msg.msg_byte, msg.msg_last);
      if (res_valid && res_ready) check_result(res);
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left--;
    end else begin
      res_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [7:0] fill_byte(input fill_t f);
    case (f)
      FILL_ZEROS: return 8'h00;
      FILL_ONES:  return 8'hFF;
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic int rand_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(0, 8);
    else if (pick < 95) return $urandom_range(9, 40);
    else return $urandom_range(41, 300);
  endfunction

  function automatic void build_msg(input msg_plan_t p);
    int len;
    int cut;
    msg_bytes.delete();
    repeat (2) msg_bytes.push_back(fill_byte(p.fill));
    msg_bytes.push_back(8'(p.count >> 8));
    msg_bytes.push_back(8'(p.count));
    repeat (BATCH_HDR_BYTES - 4) msg_bytes.push_back(fill_byte(p.fill));
    for (int k = 0; k < p.npk; k++) begin
      len = (p.dlen == RANDOM_LEN) ? rand_len() : p.dlen;
      msg_bytes.push_back(8'(len >> 8));
      msg_bytes.push_back(8'(len));
      repeat (WORD_BYTES) msg_bytes.push_back(fill_byte(p.fill));
      repeat (len) msg_bytes.push_back(fill_byte(p.fill));
    end
    repeat (p.tail) msg_bytes.push_back(8'($urandom_range(255)));
    cut = (p.cut == RANDOM_CUT) ? $urandom_range(1, msg_bytes.size()) : p.cut;
    if (cut > 0)
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg <= '{msg_byte: b, msg_last: l};
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_msg(input msg_plan_t p);
    ending_t te;
    te.typed = p.typed;
    te.r = '0;
    te.r.kind = p.ekind;
    te.r.error_code = p.ecode;
    te.r.packet_number = 16'(p.epkt);
    te.r.batch_packet_count = 16'(p.ecount);
    typed_endings.push_back(te);
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msgs_sent++;
  endtask

  // Mostly well-formed batches; some truncated at random, a few pure noise.
  task automatic send_random_msg();
    msg_plan_t p;
    int pick;
    pick = $urandom_range(99);
    p.typed = 1'b0;
    p.ekind = KIND_OK;
    p.ecode = CODE_NONE;
    p.epkt = 0;
    p.ecount = 0;
    if (pick >= 92) begin
      msg_bytes.delete();
      repeat ($urandom_range(1, 60)) msg_bytes.push_back(8'($urandom_range(255)));
    end else begin
      p.count = (pick < 3) ? $urandom_range(5, 65535) : $urandom_range(0, 3);
      p.npk = (pick < 3) ? $urandom_range(0, 2) : p.count;
      p.dlen = RANDOM_LEN;
      p.cut = (pick >= 75) ? RANDOM_CUT : NO_CUT;
      p.tail = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0;
      p.fill = FILL_RANDOM;
      build_msg(p);
    end
    send_msg(p);
  endtask

  task automatic wait_drained();
    msg_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // tail bytes give no result, so let the block settle before going on
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic emit_readback(input logic v);
    logic [31:0] rd;
    reg_access(1'b0, EMIT_ENABLE_ADDR, '0, rd);
    if (rd[0] !== v) begin
      errors++;
      $display("%0t ns: emit_enable read expected %0h, actual %0h", $time, v, rd[0]);
    end
  endtask

  task automatic set_emit(input logic v);
    logic [31:0] rd;
    reg_access(1'b1, EMIT_ENABLE_ADDR, {31'b0, v}, rd);
    emit_on = v;
    emit_readback(v);
  endtask

  initial begin
    #(CLK_PERIOD * WATCHDOG_CYCLES);
    $display("Timeout with %0d result beats outstanding", due_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int spin;
    int phase_start;
    logic emit_next;

    clear_parser();
    foreach (kind_seen[i]) kind_seen[i] = 0;
    // count, packets built, data length, cut, tail, fill, typed end beat
    directed_plan = '{
      '{0, 0, 0, 1, 0, FILL_ONES, 1, KIND_ERROR, ERR_BATCH_SHORT, 0, 0},
      '{5, 0, 0, BATCH_HDR_BYTES - 1, 0, FILL_ZEROS, 1, KIND_ERROR, ERR_BATCH_SHORT, 0, 0},
      '{0, 0, 0, NO_CUT, 0, FILL_RANDOM, 1, KIND_OK, CODE_NONE, 0, 0},
      '{0, 0, 0, NO_CUT, 6, FILL_ONES, 1, KIND_OK, CODE_NONE, 0, 0},
      '{1, 1, 0, NO_CUT, 0, FILL_RANDOM, 1, KIND_OK, CODE_NONE, 0, 1},
      '{1, 1, 3, NO_CUT, 0, FILL_ONES, 0, KIND_OK, CODE_NONE, 0, 0},
      '{2, 2, 2, BATCH_HDR_BYTES + PREFIX_BYTES + 2 + 5, 0, FILL_RANDOM,
        1, KIND_ERROR, ERR_PREFIX_CUT, 2, 2},
      '{1, 0, 0, NO_CUT, 0, FILL_RANDOM, 1, KIND_ERROR, ERR_PREFIX_CUT, 1, 1},
      '{1, 1, 4, BATCH_HDR_BYTES + PREFIX_BYTES + 2, 0, FILL_RANDOM,
        1, KIND_ERROR, ERR_DATA_CUT, 1, 1},
      '{1, 1, 4, BATCH_HDR_BYTES + PREFIX_BYTES, 0, FILL_ZEROS,
        1, KIND_ERROR, ERR_DATA_CUT, 1, 1},
      '{2, 2, 3, BATCH_HDR_BYTES + 2 * PREFIX_BYTES + 3 + 2, 0, FILL_RANDOM,
        1, KIND_ERROR, ERR_DATA_CUT, 2, 2},
      '{3, 3, 1, NO_CUT, 4, FILL_RANDOM, 0, KIND_OK, CODE_NONE, 0, 0},
      '{65535, 2, 0, NO_CUT, 0, FILL_ONES, 1, KIND_ERROR, ERR_PREFIX_CUT, 3, 65535},
      '{1, 1, 65535, BATCH_HDR_BYTES + PREFIX_BYTES + 3, 0, FILL_ONES,
        1, KIND_ERROR, ERR_DATA_CUT, 1, 1}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    emit_readback(1'b1);

    foreach (directed_plan[i]) begin
      build_msg(directed_plan[i]);
      send_msg(directed_plan[i]);
    end

    for (int pi = 0; pi < 6; pi++) begin
      wait_drained();
      case (pi)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  emit_next = 1'b1; end
        1: begin tx_idle_pct = 82; rx_stall_pct = 0;  emit_next = 1'b1; end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 82; emit_next = 1'b0; end
        3: begin tx_idle_pct = 14; rx_stall_pct = 14; emit_next = 1'b1; end
        4: begin tx_idle_pct = 0;  rx_stall_pct = 0;  emit_next = 1'b0; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 82; emit_next = 1'b1; end
      endcase
      set_emit(emit_next);
      // long receiver hold-off while beats keep coming: fills the result queue
      if (pi == 0) hold_left = 400;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        send_random_msg();
        if (pi == 3 && msgs_sent % 2 == 0) wait_drained();
      end
    end
    msg_valid <= 1'b0;

    spin = 0;
    while (due_results.size() != 0 && spin < 200000) begin
      @(posedge clk);
      spin++;
    end
    repeat (20) @(posedge clk);
    if (due_results.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected result beats never arrived", $time, due_results.size());
    end

    $display("Sent %0d messages (%0d bytes) incl. truncated, noisy and checking-only runs;",
             msgs_sent, bytes_sent);
    $display("checked %0d result beats: %0d headers, %0d data, %0d ok, %0d errors.",
             results_checked, kind_seen[KIND_HEADER], kind_seen[KIND_DATA],
             kind_seen[KIND_OK], kind_seen[KIND_ERROR]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- packet_batch_deframer.f -----
+incdir+design
design/pbd_pkg.sv
design/pbd_queue.sv
design/packet_batch_deframer.sv
bench/packet_batch_deframer_tb.sv
